@@ rtl/core/pocsag_codeword_framer_top_defines.svh @@
// Assertion macros shared by the framer RTL.
`ifndef POCSAG_CODEWORD_FRAMER_TOP_DEFINES_SVH
`define POCSAG_CODEWORD_FRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pcf_pkg.sv @@
package pcf_pkg;

   // Fixed codewords and code constants
   localparam logic [31:0] CW_SYNC     = 32'h7CD215D8;
   localparam logic [31:0] CW_IDLE     = 32'h7A89C197;
   localparam logic [10:0] BCH_GEN     = 11'h769;
   localparam logic [3:0]  PAD_NIBBLE  = 4'h3;
   localparam logic [4:0]  BATCH_WORDS = 5'd16;

   // Input commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_CHAR  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // Page kinds
   localparam logic [1:0] KIND_ALPHA   = 2'd0;
   localparam logic [1:0] KIND_NUMERIC = 2'd1;

   // Job kinds between front and back
   localparam logic [1:0] JOB_START = 2'd0;
   localparam logic [1:0] JOB_MSG   = 2'd1;
   localparam logic [1:0] JOB_END   = 2'd2;

   // Job queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Stream widths
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;

   // One unit of work for the back end
   typedef struct packed {
      logic [1:0]  kind;
      logic        has_msg;  // end of page carries a flushed message word
      logic [2:0]  frame;    // start page: frame number
      logic [20:0] data;     // 21 data bits of the coded word
   } job_type;

   // Check bits contributed by each data bit (remainder of x^(p+10))
   function automatic logic [20:0][9:0] bch_rows();
      logic [20:0][9:0] rows;
      logic [30:0]      rem;
      for (int p = 0; p < 21; p++) begin
         rem = 31'b1 << (p + 10);
         for (int b = 30; b >= 10; b--) begin
            if (rem[b]) begin
               rem = rem ^ (31'(BCH_GEN) << (b - 10));
            end
         end
         rows[p] = rem[9:0];
      end
      return rows;
   endfunction

   localparam logic [20:0][9:0] BCH_ROWS = bch_rows();

   // BCH(31,21) codeword plus even parity in bit 0
   function automatic logic [31:0] bch_word(input logic [20:0] data);
      logic [9:0]  rem;
      logic [31:0] cw;
      rem = '0;
      for (int i = 0; i < 21; i++) begin
         if (data[i]) begin
            rem = rem ^ BCH_ROWS[i];
         end
      end
      cw    = {data, rem, 1'b0};
      cw[0] = ^cw[31:1];
      return cw;
   endfunction

   function automatic logic [6:0] rev7(input logic [6:0] v);
      logic [6:0] r;
      for (int i = 0; i < 7; i++) begin
         r[i] = v[6 - i];
      end
      return r;
   endfunction

   function automatic logic [3:0] rev4(input logic [3:0] v);
      return {v[0], v[1], v[2], v[3]};
   endfunction

   // Character to BCD nibble; unknown bytes map to space
   function automatic logic [3:0] digit_nibble(input logic [7:0] ch);
      logic [3:0] nib;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         nib = ch[3:0];
      end else begin
         case (ch)
            8'h2A:        nib = 4'hA;
            8'h55, 8'h75: nib = 4'hB;
            8'h20:        nib = 4'hC;
            8'h2D:        nib = 4'hD;
            8'h29:        nib = 4'hE;
            8'h28:        nib = 4'hF;
            default:      nib = 4'hC;
         endcase
      end
      return nib;
   endfunction

endpackage

@@ rtl/core/pcf_front.sv @@
// Front end: takes items, packs characters, posts jobs to the queue.
module pcf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          command,
   input  logic [20:0]         address,
   input  logic [1:0]          function_bits,
   input  logic [1:0]          message_type,
   input  logic [7:0]          char_code,
   input  logic                queue_full,
   output logic                push,
   output pcf_pkg::job_type    job
);

   logic [25:0] alpha_bits_ff, alpha_bits_in;
   logic [4:0]  alpha_cnt_ff, alpha_cnt_in;
   logic [19:0] digit_word_ff, digit_word_in;
   logic [2:0]  digit_cnt_ff, digit_cnt_in;
   logic [1:0]  page_kind_ff, page_kind_in;

   logic        accept;
   logic        post;
   logic [25:0] ab;
   logic [4:0]  acnt;
   logic [2:0]  sh;
   logic [19:0] dw;
   logic [3:0]  nib;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;
   assign push     = accept && post;

   // Next state and job for the item on the port
   always_comb begin
      alpha_bits_in = alpha_bits_ff;
      alpha_cnt_in  = alpha_cnt_ff;
      digit_word_in = digit_word_ff;
      digit_cnt_in  = digit_cnt_ff;
      page_kind_in  = page_kind_ff;
      post          = 1'b0;
      job           = '0;
      ab            = {alpha_bits_ff[18:0], pcf_pkg::rev7(char_code[6:0])};
      acnt          = alpha_cnt_ff + 5'd7;
      sh            = 3'(acnt - 5'd20);
      nib           = pcf_pkg::rev4(pcf_pkg::digit_nibble(char_code));
      dw            = digit_word_ff;
      case (command)
         pcf_pkg::CMD_START: begin
            page_kind_in  = message_type;
            alpha_bits_in = '0;
            alpha_cnt_in  = '0;
            digit_word_in = '0;
            digit_cnt_in  = '0;
            post          = 1'b1;
            job.kind      = pcf_pkg::JOB_START;
            job.frame     = address[2:0];
            job.data      = {1'b0, address[20:3], function_bits};
         end
         pcf_pkg::CMD_CHAR: begin
            if (page_kind_ff == pcf_pkg::KIND_ALPHA) begin
               alpha_bits_in = ab;
               alpha_cnt_in  = acnt;
               if (acnt >= 5'd20) begin
                  post          = 1'b1;
                  job.kind      = pcf_pkg::JOB_MSG;
                  job.data      = {1'b1, 20'(ab >> sh)};
                  alpha_bits_in = ab & ((26'd1 << sh) - 26'd1);
                  alpha_cnt_in  = 5'(sh);
               end
            end else if (page_kind_ff == pcf_pkg::KIND_NUMERIC) begin
               for (int k = 0; k < 5; k++) begin
                  if (digit_cnt_ff == 3'(k)) begin
                     dw[4*(4-k) +: 4] = dw[4*(4-k) +: 4] | nib;
                  end
               end
               digit_word_in = dw;
               digit_cnt_in  = digit_cnt_ff + 3'd1;
               if (digit_cnt_ff == 3'd4) begin
                  post          = 1'b1;
                  job.kind      = pcf_pkg::JOB_MSG;
                  job.data      = {1'b1, dw};
                  digit_word_in = '0;
                  digit_cnt_in  = '0;
               end
            end
         end
         pcf_pkg::CMD_END: begin
            post     = 1'b1;
            job.kind = pcf_pkg::JOB_END;
            if (page_kind_ff == pcf_pkg::KIND_ALPHA && alpha_cnt_ff != 5'd0) begin
               job.has_msg = 1'b1;
               job.data    = {1'b1, 20'(alpha_bits_ff << (5'd20 - alpha_cnt_ff))};
            end else if (page_kind_ff == pcf_pkg::KIND_NUMERIC && digit_cnt_ff != 3'd0) begin
               // pad the open word with filler nibbles
               for (int k = 0; k < 5; k++) begin
                  if (3'(k) >= digit_cnt_ff) begin
                     dw[4*(4-k) +: 4] = pcf_pkg::PAD_NIBBLE;
                  end
               end
               job.has_msg = 1'b1;
               job.data    = {1'b1, dw};
            end
            alpha_bits_in = '0;
            alpha_cnt_in  = '0;
            digit_word_in = '0;
            digit_cnt_in  = '0;
         end
         default: begin
            post = 1'b0;
         end
      endcase
   end

   // Packing state
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_bits_ff <= '0;
         alpha_cnt_ff  <= '0;
         digit_word_ff <= '0;
         digit_cnt_ff  <= '0;
         page_kind_ff  <= '0;
      end else if (accept) begin
         alpha_bits_ff <= alpha_bits_in;
         alpha_cnt_ff  <= alpha_cnt_in;
         digit_word_ff <= digit_word_in;
         digit_cnt_ff  <= digit_cnt_in;
         page_kind_ff  <= page_kind_in;
      end
   end

endmodule

@@ rtl/core/pcf_queue.sv @@
`include "pocsag_codeword_framer_top_defines.svh"

// Small job FIFO between front and back end.
module pcf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pcf_pkg::job_type   job_in,
   input  logic               pop,
   output pcf_pkg::job_type   job_out,
   output logic               empty,
   output logic               full
);

   localparam logic [pcf_pkg::QUEUE_AW-1:0] LAST_PTR = pcf_pkg::QUEUE_AW'(pcf_pkg::QUEUE_DEPTH - 1);
   localparam logic [pcf_pkg::QUEUE_AW:0]   DEPTH_CNT = (pcf_pkg::QUEUE_AW + 1)'(pcf_pkg::QUEUE_DEPTH);

   pcf_pkg::job_type                mem_ff [pcf_pkg::QUEUE_DEPTH];
   logic [pcf_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pcf_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pcf_pkg::QUEUE_AW:0]      count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == DEPTH_CNT);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign job_out = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

   `PCF_ASSERT_IMP(a_no_push_full, clock, reset, push, !full, "job pushed into full queue")
   `PCF_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= DEPTH_CNT, "queue count overrun")

endmodule

@@ rtl/core/pcf_back.sv @@
`include "pocsag_codeword_framer_top_defines.svh"

// Back end: expands jobs into codewords, tracks batch position.
module pcf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  pcf_pkg::job_type   q_job,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [31:0]        out_word,
   output logic               out_last
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_LEAD_SYNC = 3'd1;
   localparam logic [2:0] S_LEAD_IDLE = 3'd2;
   localparam logic [2:0] S_CW        = 3'd3;
   localparam logic [2:0] S_FILL      = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [20:0] data_ff, data_in;
   logic [3:0]  idle_cnt_ff, idle_cnt_in;
   logic [4:0]  wib_ff, wib_in;
   logic        valid_ff, valid_in;
   logic [31:0] word_ff, word_in;
   logic        last_ff, last_in;

   logic        out_free;
   logic        emit;
   logic        fill_after;

   assign out_free   = !valid_ff || out_ready;
   assign fill_after = (kind_ff == pcf_pkg::JOB_END) && (wib_ff < pcf_pkg::BATCH_WORDS - 5'd1);

   // Word sequencer
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      data_in     = data_ff;
      idle_cnt_in = idle_cnt_ff;
      wib_in      = wib_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      word_in     = word_ff;
      last_in     = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               kind_in = q_job.kind;
               data_in = q_job.data;
               if (q_job.kind == pcf_pkg::JOB_START) begin
                  idle_cnt_in = {q_job.frame, 1'b0};
                  state_in    = S_LEAD_SYNC;
               end else if (q_job.kind == pcf_pkg::JOB_MSG || q_job.has_msg) begin
                  // full batch: sync word goes ahead of the message
                  idle_cnt_in = '0;
                  state_in    = (wib_ff >= pcf_pkg::BATCH_WORDS) ? S_LEAD_SYNC : S_CW;
               end else begin
                  state_in = (wib_ff >= pcf_pkg::BATCH_WORDS) ? S_IDLE : S_FILL;
               end
            end
         end
         S_LEAD_SYNC: begin
            if (out_free) begin
               emit     = 1'b1;
               word_in  = pcf_pkg::CW_SYNC;
               last_in  = 1'b0;
               wib_in   = '0;
               state_in = (idle_cnt_ff != 4'd0) ? S_LEAD_IDLE : S_CW;
            end
         end
         S_LEAD_IDLE: begin
            if (out_free) begin
               emit        = 1'b1;
               word_in     = pcf_pkg::CW_IDLE;
               last_in     = 1'b0;
               wib_in      = wib_ff + 5'd1;
               idle_cnt_in = idle_cnt_ff - 4'd1;
               if (idle_cnt_ff == 4'd1) begin
                  state_in = S_CW;
               end
            end
         end
         S_CW: begin
            if (out_free) begin
               emit     = 1'b1;
               word_in  = pcf_pkg::bch_word(data_ff);
               last_in  = !fill_after;
               wib_in   = wib_ff + 5'd1;
               state_in = fill_after ? S_FILL : S_IDLE;
            end
         end
         S_FILL: begin
            if (out_free) begin
               emit     = 1'b1;
               word_in  = pcf_pkg::CW_IDLE;
               last_in  = (wib_ff == pcf_pkg::BATCH_WORDS - 5'd1);
               wib_in   = wib_ff + 5'd1;
               state_in = (wib_ff == pcf_pkg::BATCH_WORDS - 5'd1) ? S_IDLE : S_FILL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (emit) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wib_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wib_ff   <= wib_in;
         valid_ff <= valid_in;
      end
   end

   // Job and output payload
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      data_ff     <= data_in;
      idle_cnt_ff <= idle_cnt_in;
      word_ff     <= word_in;
      last_ff     <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_last  = last_ff;

   `PCF_ASSERT_IMP(a_wib_range, clock, reset, 1'b1, wib_ff <= pcf_pkg::BATCH_WORDS, "batch count overrun")
   `PCF_ASSERT_IMP(a_fill_room, clock, reset, state_ff == S_FILL, wib_ff < pcf_pkg::BATCH_WORDS, "fill in full batch")
   `PCF_ASSERT_NXT(a_lead_idle_cnt, clock, reset, state_ff != S_LEAD_IDLE && state_in == S_LEAD_IDLE, idle_cnt_ff != 4'd0, "idle run entered with zero count")

endmodule

@@ rtl/core/pocsag_codeword_framer_top.sv @@
// POCSAG codeword framer.
// Input stream (req_): one item per transfer. req_tuser carries the command
// (start page, message character, end of page); req_tdata carries address,
// function bits, message type and character byte.
// Output stream (rsp_): one 32-bit codeword per transfer; rsp_tlast marks
// the final codeword caused by one input item.
// Once the back end has fetched its job, an item yields one codeword per
// cycle while rsp_tready does not hold the output: start page gives 2 to
// 16 words, a character at most 2, end of page up to 17. The back end
// fetches each job from its idle state; items that yield no job are taken
// by the front end alone.
// A four-entry job queue decouples input from output: items are taken
// while the queue has room, and req_tready drops when it is full.
// When rsp_tready is low the pending codeword holds and the back end
// pauses; the front end keeps taking items until the queue fills.
// Reset (synchronous) empties the queue, clears character buffers and the
// batch counter, and selects alphanumeric pages.
module pocsag_codeword_framer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [20:0] address, [22:21] function_bits, [24:23] message_type,
   // [32:25] char_code, [39:33] zero
   input  logic [pcf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] command
   input  logic [pcf_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] codeword
   output logic [pcf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;
   pcf_pkg::job_type   push_job;
   pcf_pkg::job_type   pop_job;

   pcf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .command       (req_tuser),
      .address       (req_tdata[20:0]),
      .function_bits (req_tdata[22:21]),
      .message_type  (req_tdata[24:23]),
      .char_code     (req_tdata[32:25]),
      .queue_full    (q_full),
      .push          (push),
      .job           (push_job)
   );

   pcf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (push_job),
      .pop     (pop),
      .job_out (pop_job),
      .empty   (q_empty),
      .full    (q_full)
   );

   pcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (pop_job),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule
